// ----- design/kvt_pkg.sv -----
// ----------------------------------------------------------------------------
// kvt_pkg
// Shared types and constants for the key/value table: sizes, action and
// status codes, and the controller-to-datapath command struct.
// ----------------------------------------------------------------------------
`default_nettype none

package kvt_pkg;

  localparam int CAPACITY = 64;
  localparam int KEY_W    = 32;
  localparam int VAL_W    = 32;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = $clog2(CAPACITY);

  typedef enum logic [1:0] {
    ACT_ADD    = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_DUPLICATE = 2'd1,
    ST_FULL      = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;  // latch the item and compare its key against all cells
    logic execute;  // apply the action and load the result register
  } kvt_cmd_t;

endpackage

`default_nettype wire

// ----- design/kvt_if.sv -----
// ----------------------------------------------------------------------------
// kvt_if
// Valid/ready channel interfaces: request items into the table and result
// items out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface kvt_req_if
  import kvt_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic [KEY_W-1:0]   key;
  logic [VAL_W-1:0]   value;

  modport source (output valid, action, key, value, input ready);
  modport sink   (input valid, action, key, value, output ready);
endinterface

interface kvt_rsp_if
  import kvt_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               found;
  logic [VAL_W-1:0]   read_value;
  logic [1:0]         status;
  logic [CNT_W-1:0]   entry_count;

  modport source (output valid, found, read_value, status, entry_count, input ready);
  modport sink   (input valid, found, read_value, status, entry_count, output ready);
endinterface

`default_nettype wire

// ----- design/kvt_ctrl.sv -----
// ----------------------------------------------------------------------------
// kvt_ctrl
// Controller: takes one item, then executes it once the result register is
// free. Owns the request ready and the result valid.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_ctrl
  import kvt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     req_valid,
  output logic          req_ready,
  output logic          rsp_valid,
  input  wire logic     rsp_ready,
  output kvt_cmd_t      cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXECUTE
  } state_t;

  state_t state;
  logic   exec_go;

  // Execute when the result register is empty or being drained
  assign exec_go   = (state == S_EXECUTE) && (!rsp_valid || rsp_ready);
  assign req_ready = (state == S_IDLE);

  assign cmd.capture = req_valid && req_ready;
  assign cmd.execute = exec_go;

  // State and result valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_EXECUTE;
          end
        end
        S_EXECUTE: begin
          if (exec_go) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase

      if (exec_go) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- design/kvt_datapath.sv -----
// ----------------------------------------------------------------------------
// kvt_datapath
// Row of entry cells with a key comparator per cell. On capture every valid
// cell compares its key; on execute the one-hot hit vector selects the
// value, drives the shift-down on remove, and the result is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_datapath
  import kvt_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire kvt_cmd_t           cmd,
  input  wire logic [1:0]         req_action,
  input  wire logic [KEY_W-1:0]   req_key,
  input  wire logic [VAL_W-1:0]   req_value,
  output logic                    rsp_found,
  output logic [VAL_W-1:0]        rsp_read_value,
  output logic [1:0]              rsp_status,
  output logic [CNT_W-1:0]        rsp_entry_count
);

  logic [KEY_W-1:0]  cell_key [CAPACITY];
  logic [VAL_W-1:0]  cell_val [CAPACITY];
  logic [CNT_W-1:0]  count;
  logic [CNT_W-1:0]  count_next;

  action_t           act;
  logic [KEY_W-1:0]  key_q;
  logic [VAL_W-1:0]  val_q;
  logic [CAPACITY-1:0] match;

  logic                hit;
  logic [VAL_W-1:0]    hit_val;
  logic [CAPACITY-1:0] at_or_after;
  logic                is_full;
  logic                do_append;
  logic                do_shift;
  logic                found_next;
  logic [VAL_W-1:0]    rv_next;
  status_t             status_next;

  // Capture the item and the per-cell match vector
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act   <= action_t'(req_action);
      key_q <= req_key;
      val_q <= req_value;
      for (int i = 0; i < CAPACITY; i++) begin
        match[i] <= (CNT_W'(i) < count) && (cell_key[i] == req_key);
      end
    end
  end

  // Hit detection, selected value and the shift mask (keys are unique)
  always_comb begin
    hit_val = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_val = hit_val | ({VAL_W{match[i]}} & cell_val[i]);
    end
    at_or_after[0] = match[0];
    for (int i = 1; i < CAPACITY; i++) begin
      at_or_after[i] = at_or_after[i-1] | match[i];
    end
  end

  assign hit     = |match;
  assign is_full = (count == CNT_W'(CAPACITY));

  // Action decode
  always_comb begin
    found_next  = 1'b0;
    rv_next     = '0;
    status_next = ST_DONE;
    count_next  = count;
    do_append   = 1'b0;
    do_shift    = 1'b0;
    unique case (act)
      ACT_ADD: begin
        if (hit) begin
          found_next  = 1'b1;
          status_next = ST_DUPLICATE;
        end else if (is_full) begin
          status_next = ST_FULL;
        end else begin
          do_append  = 1'b1;
          count_next = count + CNT_W'(1);
        end
      end
      ACT_LOOKUP: begin
        if (hit) begin
          found_next = 1'b1;
          rv_next    = hit_val;
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      ACT_REMOVE: begin
        if (hit) begin
          found_next = 1'b1;
          do_shift   = 1'b1;
          count_next = count - CNT_W'(1);
        end else begin
          status_next = ST_NOT_FOUND;
        end
      end
      ACT_CLEAR: begin
        count_next = '0;
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  // Entry cells: shift down from the hit on remove, append at the tail on add
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        if (do_shift && at_or_after[i]) begin
          cell_key[i] <= cell_key[i+1];
          cell_val[i] <= cell_val[i+1];
        end
      end
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_append && (count[IDX_W-1:0] == IDX_W'(i))) begin
          cell_key[i] <= key_q;
          cell_val[i] <= val_q;
        end
      end
    end
  end

  // Entry count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.execute) begin
      count <= count_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      rsp_found       <= found_next;
      rsp_read_value  <= rv_next;
      rsp_status      <= status_next;
      rsp_entry_count <= count_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/key_value_table.sv -----
// ----------------------------------------------------------------------------
// key_value_table
// Fixed-capacity key/value table kept in insertion order, with add, lookup,
// remove and clear actions and one result item per request item.
// ----------------------------------------------------------------------------
// Usage:
//   req: valid/ready channel carrying action, key and value. An item is
//        taken when valid and ready are both high at a clock edge.
//   rsp: valid/ready channel carrying found, read_value, status and
//        entry_count, one item per request item, in request order.
// Timing:
//   The cycle that accepts an item compares its key against all 64 entry
//   cells at once. The execute step that follows applies the action (append,
//   shift-down on remove, or clear) and loads the result register, which
//   raises rsp.valid. req.ready is low during the execute step, so no new
//   item is taken until the current one has been executed.
// Stall:
//   A waiting result does not block acceptance of the next item; that item
//   holds in its execute step until the result register is drained.
// Reset:
//   rst (synchronous, active high) empties the table and drops any pending
//   result; entry contents are left as they are and are never read.
// ----------------------------------------------------------------------------
`default_nettype none

module key_value_table
  import kvt_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  kvt_req_if.sink    req,
  kvt_rsp_if.source  rsp
);

  kvt_cmd_t cmd;

  kvt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .cmd       (cmd)
  );

  kvt_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .req_action      (req.action),
    .req_key         (req.key),
    .req_value       (req.value),
    .rsp_found       (rsp.found),
    .rsp_read_value  (rsp.read_value),
    .rsp_status      (rsp.status),
    .rsp_entry_count (rsp.entry_count)
  );

endmodule

`default_nettype wire

// ----- design/kvt_checker.sv -----
// ----------------------------------------------------------------------------
// kvt_checker
// Port-level checks on the key/value table, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module kvt_checker
  import kvt_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst,
  input wire logic             req_valid,
  input wire logic             req_ready,
  input wire logic             rsp_valid,
  input wire logic             rsp_ready,
  input wire logic             rsp_found,
  input wire logic [VAL_W-1:0] rsp_read_value,
  input wire logic [1:0]       rsp_status,
  input wire logic [CNT_W-1:0] rsp_entry_count
);

  // Count never exceeds capacity
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_entry_count <= CNT_W'(CAPACITY)))
    else $error("entry_count above capacity");

  // One item at a time: ready drops after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (req_valid && req_ready) |=> !req_ready)
    else $error("second item accepted while one is in flight");

  // Stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)
                                   && $stable(rsp_entry_count)))
    else $error("stalled result changed");

  // Status, found and value agree
  a_status_consistent: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_status == ST_DUPLICATE || rsp_status == ST_FULL
                   || rsp_status == ST_NOT_FOUND))
      |-> ((rsp_read_value == '0) && (rsp_found == (rsp_status == ST_DUPLICATE))))
    else $error("status inconsistent with found or read_value");

endmodule

bind key_value_table kvt_checker u_kvt_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_found       (rsp.found),
  .rsp_read_value  (rsp.read_value),
  .rsp_status      (rsp.status),
  .rsp_entry_count (rsp.entry_count)
);

`default_nettype wire
